// File: rtl/cna_pkg.sv
// Shared types and constants for the complex arithmetic unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package cna_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned ST_W           = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_SCALE = 3'd4
  } cna_op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } cna_status_e;

  // Per-item control that rides along the divider chain
  typedef struct packed {
    logic is_div;
    logic div_zero;
  } cna_ctl_t;

endpackage
`default_nettype wire

// File: rtl/cna_front.sv
// Product and combine stages: six multipliers, then sums, magnitudes and denominator.
// Depends on cna_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cna_front import cna_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned W    = DATA_WIDTH,
  localparam int unsigned MAGW = 2 * DATA_WIDTH + 1,
  localparam int unsigned NW   = MAGW + FRAC_BITS,
  localparam int unsigned DENW = 2 * DATA_WIDTH
) (
  input  wire  logic                        clk_i,
  input  wire  logic                        rst_ni,
  input  wire  logic                        in_valid_i,
  output logic                              in_ready_o,
  input  wire  logic [OP_W-1:0]             op_i,
  input  wire  logic signed [W-1:0]         ar_i,
  input  wire  logic signed [W-1:0]         ai_i,
  input  wire  logic signed [W-1:0]         br_i,
  input  wire  logic signed [W-1:0]         bi_i,
  input  wire  logic signed [W-1:0]         sc_i,
  output logic                              out_valid_o,
  input  wire  logic                        out_ready_i,
  output cna_ctl_t                          out_ctl_o,
  output logic [DENW-1:0]                   out_den_o,
  output logic [1:0]                        out_neg_o,
  output logic [1:0][MAGW-1:0]              out_mag_o,
  output logic [1:0][NW-1:0]                out_rem_o
);

  localparam int unsigned PW = 2 * W;

  // stage 1: products
  logic                 s1_valid_q;
  logic                 s1_ready;
  cna_op_e              op_q;
  logic signed [W-1:0]  ar_q, ai_q, br_q, bi_q;
  logic signed [PW-1:0] prr_q, pii_q, pri_q, pir_q, drr_q, dii_q;
  logic signed [W-1:0]  b1, b2;

  assign in_ready_o = !s1_valid_q || s1_ready;
  assign b1 = (cna_op_e'(op_i) == OP_SCALE) ? sc_i : br_i;
  assign b2 = (cna_op_e'(op_i) == OP_SCALE) ? sc_i : bi_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= cna_op_e'(op_i);
      ar_q  <= ar_i;
      ai_q  <= ai_i;
      br_q  <= br_i;
      bi_q  <= bi_i;
      prr_q <= PW'(ar_i) * PW'(b1);
      pii_q <= PW'(ai_i) * PW'(b2);
      pri_q <= PW'(ar_i) * PW'(bi_i);
      pir_q <= PW'(ai_i) * PW'(br_i);
      drr_q <= PW'(br_i) * PW'(br_i);
      dii_q <= PW'(bi_i) * PW'(bi_i);
    end
  end

  // stage 2: combine into sign and magnitude per lane
  logic                     s2_valid_q;
  logic signed [MAGW-1:0]   v_re, v_im;
  logic                     trunc;
  logic [DENW-1:0]          den;
  cna_ctl_t                 ctl_d;
  logic [1:0]               neg_d;
  logic [1:0][MAGW-1:0]     mag_d;
  logic [1:0][MAGW-1:0]     abs_v;

  assign s1_ready = !s2_valid_q || out_ready_i;
  assign den = DENW'(drr_q) + DENW'(dii_q);

  always_comb begin
    v_re  = '0;
    v_im  = '0;
    trunc = 1'b0;
    ctl_d = '0;
    case (op_q)
      OP_ADD: begin
        v_re = MAGW'(ar_q) + MAGW'(br_q);
        v_im = MAGW'(ai_q) + MAGW'(bi_q);
      end
      OP_SUB: begin
        v_re = MAGW'(ar_q) - MAGW'(br_q);
        v_im = MAGW'(ai_q) - MAGW'(bi_q);
      end
      OP_MUL: begin
        v_re  = MAGW'(prr_q) - MAGW'(pii_q);
        v_im  = MAGW'(pri_q) + MAGW'(pir_q);
        trunc = 1'b1;
      end
      OP_DIV: begin
        v_re = MAGW'(prr_q) + MAGW'(pii_q);
        v_im = MAGW'(pir_q) - MAGW'(pri_q);
        ctl_d.is_div   = (den != '0);
        ctl_d.div_zero = (den == '0);
      end
      OP_SCALE: begin
        v_re  = MAGW'(prr_q);
        v_im  = MAGW'(pii_q);
        trunc = 1'b1;
      end
      default: begin
        v_re = '0;
        v_im = '0;
      end
    endcase
    neg_d[0] = v_re[MAGW-1];
    neg_d[1] = v_im[MAGW-1];
    abs_v[0] = neg_d[0] ? MAGW'(-v_re) : MAGW'(v_re);
    abs_v[1] = neg_d[1] ? MAGW'(-v_im) : MAGW'(v_im);
    for (int l = 0; l < 2; l++) begin
      if (ctl_d.div_zero) begin
        mag_d[l] = '0;
      end else if (trunc) begin
        mag_d[l] = abs_v[l] >> FRAC_BITS;
      end else begin
        mag_d[l] = abs_v[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_ready) begin
      out_ctl_o <= ctl_d;
      out_den_o <= den;
      out_neg_o <= neg_d;
      out_mag_o <= mag_d;
      for (int l = 0; l < 2; l++) begin
        out_rem_o[l] <= NW'(mag_d[l]) << FRAC_BITS;
      end
    end
  end

  assign out_valid_o = s2_valid_q;

endmodule
`default_nettype wire

// File: rtl/cna_div_cell.sv
// One cell of the restoring divider chain: one quotient bit per lane, or the
// overflow guard when SHIFT equals the quotient width. Depends on cna_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cna_div_cell import cna_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned SHIFT      = 0,
  localparam int unsigned MAGW = 2 * DATA_WIDTH + 1,
  localparam int unsigned NW   = MAGW + FRAC_BITS,
  localparam int unsigned DENW = 2 * DATA_WIDTH,
  localparam int unsigned QW   = DATA_WIDTH + 1
) (
  input  wire  logic                   clk_i,
  input  wire  logic                   rst_ni,
  input  wire  logic                   in_valid_i,
  output logic                         in_ready_o,
  input  wire  cna_ctl_t               in_ctl_i,
  input  wire  logic [DENW-1:0]        in_den_i,
  input  wire  logic [1:0]             in_neg_i,
  input  wire  logic [1:0][MAGW-1:0]   in_mag_i,
  input  wire  logic [1:0][NW-1:0]     in_rem_i,
  input  wire  logic [1:0][QW-1:0]     in_quo_i,
  input  wire  logic [1:0]             in_big_i,
  output logic                         out_valid_o,
  input  wire  logic                   out_ready_i,
  output cna_ctl_t                     out_ctl_o,
  output logic [DENW-1:0]              out_den_o,
  output logic [1:0]                   out_neg_o,
  output logic [1:0][MAGW-1:0]         out_mag_o,
  output logic [1:0][NW-1:0]           out_rem_o,
  output logic [1:0][QW-1:0]           out_quo_o,
  output logic [1:0]                   out_big_o
);

  localparam int unsigned CW = NW + QW + 1;

  logic                 valid_q;
  logic [CW-1:0]        den_x;
  logic [1:0]           ge;
  logic [1:0][NW-1:0]   rem_d;
  logic [1:0][QW-1:0]   quo_d;
  logic [1:0]           big_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign den_x       = CW'(in_den_i) << SHIFT;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ge[l]    = CW'(in_rem_i[l]) >= den_x;
      rem_d[l] = in_rem_i[l];
      quo_d[l] = in_quo_i[l];
      big_d[l] = in_big_i[l];
      if (SHIFT >= QW) begin
        // guard: quotient would not fit the bits that follow
        big_d[l] = in_big_i[l] | ge[l];
      end else if (ge[l] && !in_big_i[l]) begin
        rem_d[l] = in_rem_i[l] - NW'(den_x);
        quo_d[l] = in_quo_i[l] | (QW'(1) << SHIFT);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      out_ctl_o <= in_ctl_i;
      out_den_o <= in_den_i;
      out_neg_o <= in_neg_i;
      out_mag_o <= in_mag_i;
      out_rem_o <= rem_d;
      out_quo_o <= quo_d;
      out_big_o <= big_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cna_back.sv
// Output stage: saturate each lane, pick the status, hold the result register.
// Depends on cna_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cna_back import cna_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned W    = DATA_WIDTH,
  localparam int unsigned MAGW = 2 * DATA_WIDTH + 1,
  localparam int unsigned QW   = DATA_WIDTH + 1
) (
  input  wire  logic                   clk_i,
  input  wire  logic                   rst_ni,
  input  wire  logic                   in_valid_i,
  output logic                         in_ready_o,
  input  wire  cna_ctl_t               in_ctl_i,
  input  wire  logic [1:0]             in_neg_i,
  input  wire  logic [1:0][MAGW-1:0]   in_mag_i,
  input  wire  logic [1:0][QW-1:0]     in_quo_i,
  input  wire  logic [1:0]             in_big_i,
  output logic                         out_valid_o,
  input  wire  logic                   out_ready_i,
  output logic [1:0][W-1:0]            out_res_o,
  output logic [ST_W-1:0]              out_status_o
);

  localparam logic [MAGW-1:0] LIM_POS = (MAGW'(1) << (W - 1)) - MAGW'(1);
  localparam logic [MAGW-1:0] LIM_NEG = MAGW'(1) << (W - 1);

  logic                  valid_q;
  logic [1:0][MAGW-1:0]  m;
  logic [1:0][MAGW-1:0]  lim;
  logic [1:0]            ovf;
  logic [1:0][W-1:0]     res_d;
  cna_status_e           st_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      m[l]   = in_ctl_i.is_div ? MAGW'(in_quo_i[l]) : in_mag_i[l];
      lim[l] = in_neg_i[l] ? LIM_NEG : LIM_POS;
      ovf[l] = (in_ctl_i.is_div && in_big_i[l]) || (m[l] > lim[l]);
      if (ovf[l]) begin
        m[l] = lim[l];
      end
      res_d[l] = in_neg_i[l] ? W'(-m[l]) : W'(m[l]);
    end
    if (in_ctl_i.div_zero) begin
      st_d = ST_DIV0;
    end else if (ovf != 2'b00) begin
      st_d = ST_OVF;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      out_res_o    <= res_d;
      out_status_o <= st_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/complex_number_alu_top.sv
// Top level of the complex arithmetic unit: front stages, divider cell chain, output stage.
// Depends on cna_pkg, cna_front, cna_div_cell and cna_back.
//
//  channel   | direction | tdata                                  | tuser
//  ----------+-----------+----------------------------------------+------------
//  s_*       | in        | lhs_real, lhs_imag, rhs_real, rhs_imag,| req_type
//            |           | scale_factor (low to high)             |
//  m_*       | out       | res_real, res_imag (low to high)       | status
//
// One transfer is taken per clock unless the chain is backed up; each item passes through one
// product stage, one combine stage, DATA_WIDTH + 2 divider cells (one overflow guard, then
// one quotient bit each) and the output register. Every item walks the whole chain.
// Each stage advances when its successor is empty or moving, so bubbles collapse and
// input keeps flowing while a result waits at the output, until every one of the
// DATA_WIDTH + 5 stages holds an item. Reset clears only the valid flags; the data
// registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module complex_number_alu_top import cna_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned IDW = ((5 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned ODW = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             s_tvalid_i,
  output logic                   s_tready_o,
  // lhs_real, lhs_imag, rhs_real, rhs_imag, scale_factor; zero padded
  input  wire  logic [IDW-1:0]   s_tdata_i,
  // req_type
  input  wire  logic [OP_W-1:0]  s_tuser_i,
  output logic                   m_tvalid_o,
  input  wire  logic             m_tready_i,
  // res_real, res_imag; zero padded
  output logic [ODW-1:0]         m_tdata_o,
  // status
  output logic [ST_W-1:0]        m_tuser_o
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned MAGW = 2 * DATA_WIDTH + 1;
  localparam int unsigned NW   = MAGW + FRAC_BITS;
  localparam int unsigned DENW = 2 * DATA_WIDTH;
  localparam int unsigned QW   = DATA_WIDTH + 1;
  localparam int unsigned NC   = QW + 1;

  // chain links; link 0 feeds the first cell, link NC feeds the output stage
  logic                  c_valid [NC+1];
  logic                  c_ready [NC+1];
  cna_ctl_t              c_ctl   [NC+1];
  logic [DENW-1:0]       c_den   [NC+1];
  logic [1:0]            c_neg   [NC+1];
  logic [1:0][MAGW-1:0]  c_mag   [NC+1];
  logic [1:0][NW-1:0]    c_rem   [NC+1];
  logic [1:0][QW-1:0]    c_quo   [NC+1];
  logic [1:0]            c_big   [NC+1];

  logic [1:0][W-1:0]     res;

  cna_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .op_i        (s_tuser_i),
    .ar_i        (s_tdata_i[0*W +: W]),
    .ai_i        (s_tdata_i[1*W +: W]),
    .br_i        (s_tdata_i[2*W +: W]),
    .bi_i        (s_tdata_i[3*W +: W]),
    .sc_i        (s_tdata_i[4*W +: W]),
    .out_valid_o (c_valid[0]),
    .out_ready_i (c_ready[0]),
    .out_ctl_o   (c_ctl[0]),
    .out_den_o   (c_den[0]),
    .out_neg_o   (c_neg[0]),
    .out_mag_o   (c_mag[0]),
    .out_rem_o   (c_rem[0])
  );

  // quotient starts empty, no overflow seen yet
  assign c_quo[0] = '0;
  assign c_big[0] = '0;

  // guard cell first, then quotient bits from the top down
  for (genvar k = 0; k < NC; k++) begin : g_cell
    cna_div_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .SHIFT      (QW - k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c_valid[k]),
      .in_ready_o  (c_ready[k]),
      .in_ctl_i    (c_ctl[k]),
      .in_den_i    (c_den[k]),
      .in_neg_i    (c_neg[k]),
      .in_mag_i    (c_mag[k]),
      .in_rem_i    (c_rem[k]),
      .in_quo_i    (c_quo[k]),
      .in_big_i    (c_big[k]),
      .out_valid_o (c_valid[k+1]),
      .out_ready_i (c_ready[k+1]),
      .out_ctl_o   (c_ctl[k+1]),
      .out_den_o   (c_den[k+1]),
      .out_neg_o   (c_neg[k+1]),
      .out_mag_o   (c_mag[k+1]),
      .out_rem_o   (c_rem[k+1]),
      .out_quo_o   (c_quo[k+1]),
      .out_big_o   (c_big[k+1])
    );
  end

  cna_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (c_valid[NC]),
    .in_ready_o   (c_ready[NC]),
    .in_ctl_i     (c_ctl[NC]),
    .in_neg_i     (c_neg[NC]),
    .in_mag_i     (c_mag[NC]),
    .in_quo_i     (c_quo[NC]),
    .in_big_i     (c_big[NC]),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_res_o    (res),
    .out_status_o (m_tuser_o)
  );

  // pack real part low, imaginary part above, pad with zeros
  assign m_tdata_o = ODW'({res[1], res[0]});

endmodule
`default_nettype wire

// File: sim/complex_number_alu_checker.sv
// Checker for the complex arithmetic unit: watches both stream channels, predicts each result.
// Depends on cna_pkg; instantiated by complex_number_alu_top_tb beside the block.
`timescale 1ns / 1ps
module complex_number_alu_checker import cna_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [159:0] s_tdata_i,
  input  logic [2:0]   s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [63:0]  m_tdata_i,
  input  logic [1:0]   m_tuser_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cplx_result_t;

  cplx_result_t results_due[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count_o++;
  endtask

  // Shift off the fraction, rounding toward zero
  function automatic logic signed [159:0] drop_frac(input logic signed [159:0] v);
    drop_frac = (v < 0) ? -((-v) >> FRAC_BITS_DEF) : (v >> FRAC_BITS_DEF);
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [159:0] v, inout logic ovf);
    logic signed [159:0] hi_lim;
    logic signed [159:0] lo_lim;
    hi_lim = 160'sh7FFF_FFFF;
    lo_lim = -160'sh8000_0000;
    if (v > hi_lim) begin
      ovf = 1'b1;
      clamp32 = 32'h7FFF_FFFF;
    end else if (v < lo_lim) begin
      ovf = 1'b1;
      clamp32 = 32'h8000_0000;
    end else begin
      clamp32 = v[31:0];
    end
  endfunction

  // Exact complex result of one operation, then saturation
  function automatic cplx_result_t complex_op(input logic [2:0] op, input logic [159:0] d);
    logic signed [159:0] ar, ai, br, bi, sf, vr, vi, nr, ni;
    logic [159:0] den, mr, mi;
    logic ovf;
    cplx_result_t r;
    ar = $signed(d[31:0]);
    ai = $signed(d[63:32]);
    br = $signed(d[95:64]);
    bi = $signed(d[127:96]);
    sf = $signed(d[159:128]);
    vr = '0;
    vi = '0;
    ovf = 1'b0;
    r.st = ST_OK;
    case (op)
      OP_ADD: begin
        vr = ar + br;
        vi = ai + bi;
      end
      OP_SUB: begin
        vr = ar - br;
        vi = ai - bi;
      end
      OP_MUL: begin
        vr = drop_frac(ar * br - ai * bi);
        vi = drop_frac(ar * bi + ai * br);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.st = ST_DIV0;
        end else begin
          nr = ar * br + ai * bi;
          ni = ai * br - ar * bi;
          mr = (nr < 0) ? -nr : nr;
          mi = (ni < 0) ? -ni : ni;
          mr = (mr << FRAC_BITS_DEF) / den;
          mi = (mi << FRAC_BITS_DEF) / den;
          vr = (nr < 0) ? -$signed(mr) : $signed(mr);
          vi = (ni < 0) ? -$signed(mi) : $signed(mi);
        end
      end
      OP_SCALE: begin
        vr = drop_frac(ar * sf);
        vi = drop_frac(ai * sf);
      end
      default: ;
    endcase
    r.re = clamp32(vr, ovf);
    r.im = clamp32(vi, ovf);
    if (r.st == ST_OK && ovf) r.st = ST_OVF;
    complex_op = r;
  endfunction

  always @(posedge clk_i) begin
    cplx_result_t due;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) results_due.push_back(complex_op(s_tuser_i, s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (results_due.size() == 0) begin
          report($sformatf("unexpected result re=%h im=%h st=%0d",
                           m_tdata_i[31:0], m_tdata_i[63:32], m_tuser_i));
        end else begin
          due = results_due.pop_front();
          if (m_tdata_i[31:0] !== due.re)
            report($sformatf("res_real %h, want %h", m_tdata_i[31:0], due.re));
          if (m_tdata_i[63:32] !== due.im)
            report($sformatf("res_imag %h, want %h", m_tdata_i[63:32], due.im));
          if (m_tuser_i !== due.st)
            report($sformatf("status %0d, want %0d", m_tuser_i, due.st));
        end
      end
    end
    pending_o = results_due.size();
  end

endmodule

// File: sim/complex_number_alu_top_tb.sv
// Testbench top for complex_number_alu_top: clock, reset, stimulus, receiver stalls, verdict.
// Depends on cna_pkg, the block and complex_number_alu_checker.
`timescale 1ns / 1ps
module complex_number_alu_top_tb;
  import cna_pkg::*;

  localparam int unsigned NUM_RANDOM = 950;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  // lhs_real, lhs_imag, rhs_real, rhs_imag, scale_factor (low to high)
  logic [159:0] s_tdata_i = '0;
  // req_type
  logic [2:0]   s_tuser_i = '0;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  // res_real, res_imag (low to high)
  logic [63:0]  m_tdata_o;
  // status
  logic [1:0]   m_tuser_o;

  int fail_count;
  int pending;
  int burst_left = 0;
  int op_sent[8];
  bit long_hold_req = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  complex_number_alu_top i_dut (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tuser_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tuser_o
  );

  complex_number_alu_checker i_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i, .s_tready_i(s_tready_o), .s_tdata_i, .s_tuser_i,
    .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o), .m_tuser_i(m_tuser_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Offer one item and hold it until the transfer; end a burst with a gap so valid is
  // never dropped and raised in the same step.
  task automatic offer(input logic [2:0] op, input logic [31:0] ar, ai, br, bi, sf);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {sf, bi, br, ai, ar};
    do @(posedge clk_i); while (!s_tready_o);
    op_sent[op]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      // Some bursts are long runs with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // Operand picker: extremes, small Q16.16 values, or full-range noise
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: pick_operand = 32'h8000_0000;
      1: pick_operand = 32'h7FFF_FFFF;
      2: pick_operand = 32'h0000_0000;
      3, 4, 5: pick_operand = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: pick_operand = $urandom;
    endcase
  endfunction

  // Receiver: cycles through always-ready, light and heavy stall patterns; on request
  // hold off for a long stretch so the pipeline fills and backs up the input.
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      if (long_hold_req) begin
        m_tready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        case ((cyc / 97) % 3)
          0: m_tready_i <= 1'b1;
          1: m_tready_i <= ($urandom_range(0, 9) != 0);
          default: m_tready_i <= ($urandom_range(0, 1) != 0);
        endcase
        @(posedge clk_i);
        cyc++;
      end
    end
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int wait_cyc;
    logic [2:0] op;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation, extremes, overflow, divide by zero, unknown codes
    offer(OP_ADD,   32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0);
    offer(OP_ADD,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
    offer(OP_ADD,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    offer(OP_SUB,   32'h0005_0000, 32'h0001_8000, 32'h0002_0000, 32'h0003_0000, 32'h0);
    offer(OP_SUB,   32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
    offer(OP_SUB,   32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    offer(OP_MUL,   32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0);
    offer(OP_MUL,   32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0);
    offer(OP_MUL,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    offer(OP_MUL,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    offer(OP_DIV,   32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
    offer(OP_DIV,   32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0);
    offer(OP_DIV,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0);
    offer(OP_DIV,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    offer(OP_DIV,   32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    offer(OP_DIV,   32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0003, 32'h0);
    offer(OP_SCALE, 32'h0003_0000, 32'hFFFE_0000, 32'h0, 32'h0, 32'h0000_8000);
    offer(OP_SCALE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000);
    offer(OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
    offer(OP_SCALE, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(3'd5, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    offer(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(3'd7, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    // Random: mostly valid operations, a few unknown codes, zero divisors now and then
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 400) long_hold_req = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if (op == OP_DIV && $urandom_range(0, 9) == 0)
        offer(op, pick_operand(), pick_operand(), 32'h0, 32'h0, $urandom);
      else
        offer(op, pick_operand(), pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    s_tvalid_i <= 1'b0;

    wait_cyc = 0;
    while (pending != 0 && wait_cyc < 100000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (60) @(posedge clk_i);

    $display("Run covered add %0d, sub %0d, mul %0d, div %0d, scale %0d, unknown %0d items,",
             op_sent[OP_ADD], op_sent[OP_SUB], op_sent[OP_MUL], op_sent[OP_DIV],
             op_sent[OP_SCALE], op_sent[5] + op_sent[6] + op_sent[7]);
    $display("with bursty input, output stalls and one long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (pending != 0) $display("%0d results never arrived", pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cna_pkg.sv
rtl/cna_front.sv
rtl/cna_div_cell.sv
rtl/cna_back.sv
rtl/complex_number_alu_top.sv
sim/complex_number_alu_checker.sv
sim/complex_number_alu_top_tb.sv
